[rtl/mspd_pkg.sv]
// Package for the MSP v1 telemetry deframer: parser phases, status codes,
// frame constants and the structs passed between the parser and the decoder.
// No dependencies.
package mspd_pkg;

    localparam int PAYLOAD_MAX = 16;
    // Only the first bytes of a payload are ever decoded, so only these are kept.
    localparam int STORE_BYTES = 12;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_EM     = 8'h4D;
    localparam logic [7:0] CH_ARROW  = 8'h3E;

    localparam logic [7:0] GPS_ID_RESET  = 8'd106;
    localparam logic [7:0] BATT_ID_RESET = 8'd110;
    localparam logic [7:0] NAV_ID_RESET  = 8'd121;

    localparam logic [1:0] CFG_GPS_ID  = 2'd0;
    localparam logic [1:0] CFG_BATT_ID = 2'd1;
    localparam logic [1:0] CFG_NAV_ID  = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_DOLLAR  = 3'd1,
        PH_EM      = 3'd2,
        PH_ARROW   = 3'd3,
        PH_SIZE    = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHECK   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_GPS      = 3'd0,
        ST_BATTERY  = 3'd1,
        ST_NAV      = 3'd2,
        ST_OTHER    = 3'd3,
        ST_CHECKSUM = 3'd4,
        ST_OVERSIZE = 3'd5
    } t_status;

    typedef logic [STORE_BYTES-1:0][7:0] t_store;

    typedef struct packed {
        logic       done;
        logic       chk_ok;
        logic       oversize;
        logic [7:0] command;
    } t_frame_info;

    typedef struct packed {
        logic [7:0] nav_state;
        logic [15:0] battery_voltage;
        logic [15:0] gps_altitude;
        logic [31:0] longitude_raw;
        logic [31:0] latitude_raw;
        logic [7:0] satellite_count;
        logic [7:0] gps_fix;
        logic [7:0] frame_command;
    } t_result;

endpackage

[rtl/mspd_parser.sv]
// Frame tracker for the MSP v1 deframer: header match, size, command,
// payload store and running checksum. Depends on mspd_pkg.
module mspd_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    output mspd_pkg::t_frame_info o_info,
    output mspd_pkg::t_store     o_store
);
    import mspd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_size, n_size;
    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_seen, n_seen;
    t_store     r_store;
    logic [7:0] w_seen_inc;

    assign w_seen_inc = r_seen + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_size  <= '0;
            r_cmd   <= '0;
            r_xor   <= '0;
            r_seen  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_size  <= n_size;
            r_cmd   <= n_cmd;
            r_xor   <= n_xor;
            r_seen  <= n_seen;
        end
    end

    // Bytes past the kept part of the payload are counted but dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
        end else if (i_step && r_phase == PH_PAYLOAD) begin
            for (int i = 0; i < STORE_BYTES; i++) begin
                if (r_seen == 8'(i)) begin
                    r_store[i] <= i_byte;
                end
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_size  = r_size;
        n_cmd   = r_cmd;
        n_xor   = r_xor;
        n_seen  = r_seen;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_byte == CH_DOLLAR) begin
                    n_phase = PH_DOLLAR;
                end
            end
            PH_DOLLAR: begin
                n_phase = (i_byte == CH_EM) ? PH_EM : PH_IDLE;
            end
            PH_EM: begin
                n_phase = (i_byte == CH_ARROW) ? PH_ARROW : PH_IDLE;
            end
            PH_ARROW: begin
                n_size  = i_byte;
                n_xor   = i_byte;
                n_phase = PH_SIZE;
            end
            PH_SIZE: begin
                n_cmd   = i_byte;
                n_xor   = r_xor ^ i_byte;
                n_seen  = '0;
                n_phase = (r_size == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_xor  = r_xor ^ i_byte;
                n_seen = w_seen_inc;
                if (w_seen_inc >= r_size) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign o_info.done     = i_step && (r_phase == PH_CHECK);
    assign o_info.chk_ok   = (i_byte == r_xor);
    assign o_info.oversize = (r_size > 8'(PAYLOAD_MAX));
    assign o_info.command  = r_cmd;
    assign o_store         = r_store;

endmodule

[rtl/mspd_decode.sv]
// Result decoder for the MSP v1 deframer: picks the status from the
// checksum, size and configured command ids, and unpacks payload fields.
// Depends on mspd_pkg.
module mspd_decode (
    input  mspd_pkg::t_frame_info i_info,
    input  mspd_pkg::t_store      i_store,
    input  logic [7:0]            i_gps_id,
    input  logic [7:0]            i_batt_id,
    input  logic [7:0]            i_nav_id,
    output mspd_pkg::t_status     o_status,
    output mspd_pkg::t_result     o_result
);
    import mspd_pkg::*;

    always_comb begin
        o_result               = '0;
        o_result.frame_command = i_info.command;
        // Checksum failure outranks oversize, which outranks decoding.
        if (!i_info.chk_ok) begin
            o_status = ST_CHECKSUM;
        end else if (i_info.oversize) begin
            o_status = ST_OVERSIZE;
        end else if (i_info.command == i_gps_id) begin
            o_status                 = ST_GPS;
            o_result.gps_fix         = i_store[0];
            o_result.satellite_count = i_store[1];
            o_result.latitude_raw    = {i_store[5], i_store[4], i_store[3], i_store[2]};
            o_result.longitude_raw   = {i_store[9], i_store[8], i_store[7], i_store[6]};
            o_result.gps_altitude    = {i_store[11], i_store[10]};
        end else if (i_info.command == i_batt_id) begin
            o_status                 = ST_BATTERY;
            o_result.battery_voltage = {i_store[1], i_store[0]};
        end else if (i_info.command == i_nav_id) begin
            o_status           = ST_NAV;
            o_result.nav_state = i_store[0];
        end else begin
            o_status = ST_OTHER;
        end
    end

endmodule

[rtl/msp_telemetry_deframer_unit.sv]
// MSP v1 telemetry deframer, top level: input register, frame parser,
// decoder, output register and configuration registers.
// Depends on mspd_pkg, mspd_parser and mspd_decode.
//
// Usage: received serial bytes enter on the s_axis channel, one byte per
// request. Every byte is consumed; only the checksum byte of a response
// frame ('$' 'M' '>' size command payload checksum) yields a result on the
// m_axis channel. The result carries the frame status in m_axis_tuser and
// the command and decoded GPS, battery or navigation fields in m_axis_tdata.
// A byte is held in the input register and then processed into the output
// register, which holds the result of a checksum byte. One byte per cycle
// is sustained while the receiver does not stall: the parser updates its
// state and the payload store once per byte. The command ids must be written
// through the i_cfg port while the block is idle; the block does not enforce it.
// Reset returns the parser to idle, clears the payload store and restores
// the default command ids. When the receiver stalls, the pending result
// stays in the output register and the byte behind it waits in the input
// register; s_axis_tready drops once both are occupied.
module msp_telemetry_deframer_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // rx_byte[7:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // frame_command[7:0], gps_fix[15:8], satellite_count[23:16],
    // latitude_raw[55:24], longitude_raw[87:56], gps_altitude[103:88],
    // battery_voltage[119:104], nav_state[127:120]
    output logic [127:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,   // frame_status[2:0]
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data
);
    import mspd_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_status     r_out_status;
    t_result     r_out_result;
    logic [7:0]  r_gps_id, r_batt_id, r_nav_id;

    logic        w_advance;
    t_frame_info w_info;
    t_store      w_store;
    t_status     w_status;
    t_result     w_result;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gps_id  <= GPS_ID_RESET;
            r_batt_id <= BATT_ID_RESET;
            r_nav_id  <= NAV_ID_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GPS_ID:  r_gps_id  <= i_cfg_data;
                CFG_BATT_ID: r_batt_id <= i_cfg_data;
                CFG_NAV_ID:  r_nav_id  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    mspd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_byte  (r_in_byte),
        .o_info  (w_info),
        .o_store (w_store)
    );

    mspd_decode u_decode (
        .i_info    (w_info),
        .i_store   (w_store),
        .i_gps_id  (r_gps_id),
        .i_batt_id (r_batt_id),
        .i_nav_id  (r_nav_id),
        .o_status  (w_status),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_info.done;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_info.done) begin
            r_out_status <= w_status;
            r_out_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = r_out_result;

`ifndef SYNTHESIS
    a_result_follows_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_info.done) |=> m_axis_tvalid)
        else $error("checksum byte did not produce a result");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ST_OVERSIZE))
        else $error("result status out of range");

    a_non_gps_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_GPS) |-> (m_axis_tdata[103:8] == '0))
        else $error("GPS fields set on a non-GPS result");
`endif

endmodule
